>>> rtl/core/nnf_pkg.sv
// shared types and constants for the nullable nonterminal finder
`default_nettype none

package nnf_pkg;

	// field widths of one rule and one result
	localparam int LHS_W        = 5;
	localparam int RHS_W        = 26;
	localparam int LETTERS      = 2 ** LHS_W;
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 8;

	// result list limit and its counter width
	localparam int OUT_LIMIT    = 64;
	localparam int OUT_CNT_W    = $clog2(OUT_LIMIT + 1);

	// front to back queue
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	// defaults for the top level parameters
	localparam int DEF_MAX_RULES   = 64;
	localparam int DEF_NUM_SYMBOLS = 26;

	// one grammar rule
	typedef struct packed {
		logic             term;
		logic [RHS_W-1:0] rhs;
		logic [LHS_W-1:0] lhs;
	} rule_t;

	// classified item from the front
	typedef struct packed {
		logic  store;
		logic  last;
		rule_t rule;
	} cmd_t;

	// rule store entry
	typedef struct packed {
		logic  done;
		rule_t rule;
	} mem_entry_t;

	// one result item
	typedef struct packed {
		logic             last;
		logic             found;
		logic [LHS_W-1:0] symbol;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/core/nullable_nonterminal_finder.sv
// top level of the nullable nonterminal finder
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata rule fields, s_tlast ends the grammar
// m_*      out  m_tvalid/m_tready   m_tdata symbol, m_tuser found, m_tlast ends the list
//
// rules enter one per cycle, while the queue has room, through a four entry queue into
// the rule store; after the final rule, fixpoint passes read the stored rules through the
// store's single read port, repeated until a pass marks nothing
// emission sweeps the store once per distinct letter found, stopping early at the result
// limit, and one last item closes the list; a stalled output holds the sweep in place
// reset clears all control state at once; no clearing pass is needed
`default_nettype none

module nullable_nonterminal_finder #(
	parameter int MAX_RULES   = nnf_pkg::DEF_MAX_RULES,
	parameter int NUM_SYMBOLS = nnf_pkg::DEF_NUM_SYMBOLS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// lhs [4:0], rhs_nonterminals [30:5], rhs_has_terminal [31]
	input  wire logic [nnf_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// symbol [4:0], zero [7:5]
	output logic [nnf_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// found [0]
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import nnf_pkg::*;

	localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W  = $clog2(MAX_RULES + 1);
	localparam int CMD_W  = $bits(cmd_t);
	localparam int QW     = ADDR_W + CMD_W;

	cmd_t              front_cmd;
	logic [ADDR_W-1:0] front_addr;
	logic              push_vld;
	logic              push_rdy;
	logic [QW-1:0]     q_data;
	logic              q_vld;
	logic              q_rdy;
	cmd_t              q_cmd;
	logic [ADDR_W-1:0] q_addr;
	res_t              res;

	nnf_front #(
		.MAX_RULES (MAX_RULES),
		.ADDR_W    (ADDR_W),
		.CNT_W     (CNT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push_vld (push_vld),
		.push_rdy (push_rdy),
		.cmd      (front_cmd),
		.addr     (front_addr)
	);

	nnf_queue #(
		.W (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (push_vld),
		.in_rdy   (push_rdy),
		.in_data  ({front_addr, front_cmd}),
		.out_vld  (q_vld),
		.out_rdy  (q_rdy),
		.out_data (q_data)
	);

	// unpack queue entry
	assign q_cmd  = cmd_t'(q_data[CMD_W-1:0]);
	assign q_addr = q_data[QW-1 -: ADDR_W];

	nnf_back #(
		.MAX_RULES   (MAX_RULES),
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_vld   (q_vld),
		.q_rdy   (q_rdy),
		.q_cmd   (q_cmd),
		.q_addr  (q_addr),
		.res_vld (m_tvalid),
		.res_rdy (m_tready),
		.res     (res)
	);

	// result item onto the output stream
	assign m_tdata = OUT_TDATA_W'(res.symbol);
	assign m_tuser = res.found;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

>>> rtl/core/nnf_front.sv
// front: accepts rule items, assigns store slots and drops rules beyond capacity
`default_nettype none

module nnf_front #(
	parameter int MAX_RULES = nnf_pkg::DEF_MAX_RULES,
	parameter int ADDR_W    = 6,
	parameter int CNT_W     = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [nnf_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic                          s_tlast,
	output logic                               push_vld,
	input  wire logic                          push_rdy,
	output nnf_pkg::cmd_t                      cmd,
	output logic [ADDR_W-1:0]                  addr
);
	import nnf_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             accept;

	// classify the incoming rule
	assign s_tready      = push_rdy;
	assign push_vld      = s_tvalid;
	assign accept        = s_tvalid && push_rdy;
	assign cmd.store     = (cnt_q < CNT_W'(MAX_RULES));
	assign cmd.last      = s_tlast;
	assign cmd.rule.lhs  = s_tdata[LHS_W-1:0];
	assign cmd.rule.rhs  = s_tdata[LHS_W +: RHS_W];
	assign cmd.rule.term = s_tdata[LHS_W + RHS_W];
	assign addr          = cnt_q[ADDR_W-1:0];

	// slot counter, restarts with each grammar
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				cnt_q <= '0;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nnf_queue.sv
// short fifo between front and back
`default_nettype none

module nnf_queue #(
	parameter int W = 40
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_vld,
	output logic              in_rdy,
	input  wire logic [W-1:0] in_data,
	output logic              out_vld,
	input  wire logic         out_rdy,
	output logic [W-1:0]      out_data
);
	import nnf_pkg::*;

	logic [W-1:0]      slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              push;
	logic              pop;

	// handshake on both sides
	assign in_rdy   = (fill_q != (QPTR_W + 1)'(QUEUE_DEPTH));
	assign out_vld  = (fill_q != '0);
	assign push     = in_vld && in_rdy;
	assign pop      = out_vld && out_rdy;
	assign out_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
		else $error("queue fill level above depth");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("queue fill level missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers apart while empty");
`endif

endmodule

`default_nettype wire

>>> rtl/core/nnf_back.sv
// back: rule store, fixpoint passes and sorted emission of nullable rules
`default_nettype none

module nnf_back #(
	parameter int MAX_RULES   = nnf_pkg::DEF_MAX_RULES,
	parameter int NUM_SYMBOLS = nnf_pkg::DEF_NUM_SYMBOLS,
	parameter int ADDR_W      = 6,
	parameter int CNT_W       = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_vld,
	output logic                   q_rdy,
	input  wire nnf_pkg::cmd_t     q_cmd,
	input  wire logic [ADDR_W-1:0] q_addr,
	output logic                   res_vld,
	input  wire logic              res_rdy,
	output nnf_pkg::res_t          res
);
	import nnf_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_PASS, ST_EMIT, ST_FLUSH} state_t;

	state_t                 state_q;
	mem_entry_t             mem [MAX_RULES];
	mem_entry_t             rd_s1;
	logic                   rd_vld_s1;
	logic [ADDR_W-1:0]      rd_idx_s1;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic [NUM_SYMBOLS-1:0] nullable_q;
	logic [NUM_SYMBOLS-1:0] lhs_bit;
	logic [LETTERS-1:0]     emit_mask_q;
	logic [LETTERS-1:0]     letter_bit;
	logic [LETTERS-1:0]     mask_left;
	logic                   changed_q;
	logic [OUT_CNT_W-1:0]   found_q;
	logic                   pend_vld_q;
	logic [LHS_W-1:0]       pend_sym_q;
	logic [LHS_W-1:0]       letter;
	res_t                   out_q;
	logic                   out_vld_q;
	logic [RHS_W-1:0]       null_view;
	logic                   space;
	logic                   issue;
	logic                   fire;
	logic                   match;
	logic                   stall;
	logic                   sweep_end;
	logic                   load_pop;
	logic                   we;
	logic [ADDR_W-1:0]      wa;
	mem_entry_t             wd;

	// nullable set seen through the right side mask, unknown symbols never nullable
	for (genvar k = 0; k < RHS_W; k++) begin : g_view
		if (k < NUM_SYMBOLS) begin : g_in
			assign null_view[k] = nullable_q[k];
		end else begin : g_out
			assign null_view[k] = 1'b0;
		end
	end

	// nullable bit of the rule under test, none for letters beyond the set
	for (genvar k = 0; k < NUM_SYMBOLS; k++) begin : g_lhs
		assign lhs_bit[k] = (32'(rd_s1.rule.lhs) == k);
	end

	// lowest letter still to emit
	always_comb begin
		letter = '0;
		for (int k = LETTERS - 1; k >= 0; k--) begin
			if (emit_mask_q[k]) begin
				letter = LHS_W'(k);
			end
		end
	end

	assign letter_bit = LETTERS'(1) << letter;
	assign mask_left  = emit_mask_q & ~letter_bit;

	// sweep control
	assign space     = !out_vld_q || res_rdy;
	assign q_rdy     = (state_q == ST_LOAD);
	assign load_pop  = q_vld && q_rdy;
	assign fire      = (state_q == ST_PASS) && rd_vld_s1 && !rd_s1.done && !rd_s1.rule.term
		&& ((rd_s1.rule.rhs & ~null_view) == '0);
	assign match     = (state_q == ST_EMIT) && rd_vld_s1 && rd_s1.done
		&& (rd_s1.rule.lhs == letter);
	assign stall     = match && pend_vld_q && !space;
	assign sweep_end = (idx_q == cnt_q) && !rd_vld_s1;
	assign issue     = ((state_q == ST_PASS) || ((state_q == ST_EMIT) && !stall))
		&& (idx_q < cnt_q);

	// store write port: loading or marking a rule done
	always_comb begin
		we = 1'b0;
		wa = q_addr;
		wd = '{done: 1'b0, rule: q_cmd.rule};
		if (load_pop && q_cmd.store) begin
			we = 1'b1;
		end else if (fire) begin
			we = 1'b1;
			wa = rd_idx_s1;
			wd = '{done: 1'b1, rule: rd_s1.rule};
		end
	end

	// rule store with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (issue) begin
			rd_s1     <= mem[idx_q[ADDR_W-1:0]];
			rd_idx_s1 <= idx_q[ADDR_W-1:0];
		end
	end

	// sequencer, result register and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			rd_vld_s1   <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			nullable_q  <= '0;
			emit_mask_q <= '0;
			changed_q   <= 1'b0;
			found_q     <= '0;
			pend_vld_q  <= 1'b0;
			pend_sym_q  <= '0;
			out_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (out_vld_q && res_rdy) begin
				out_vld_q <= 1'b0;
			end
			if (!stall) begin
				rd_vld_s1 <= issue;
			end
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (load_pop) begin
						if (q_cmd.store) begin
							cnt_q <= CNT_W'(q_addr) + 1'b1;
						end
						if (q_cmd.last) begin
							idx_q     <= '0;
							changed_q <= 1'b0;
							state_q   <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					if (fire) begin
						nullable_q  <= nullable_q | lhs_bit;
						emit_mask_q <= emit_mask_q | (LETTERS'(1) << rd_s1.rule.lhs);
						changed_q   <= 1'b1;
					end else if (sweep_end) begin
						idx_q     <= '0;
						changed_q <= 1'b0;
						if (!changed_q) begin
							state_q <= (emit_mask_q == '0) ? ST_FLUSH : ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (match && !stall) begin
						if (pend_vld_q) begin
							out_q     <= '{last: 1'b0, found: 1'b1, symbol: pend_sym_q};
							out_vld_q <= 1'b1;
						end
						pend_vld_q <= 1'b1;
						pend_sym_q <= letter;
						found_q    <= found_q + 1'b1;
						if (found_q == OUT_CNT_W'(OUT_LIMIT - 1)) begin
							state_q <= ST_FLUSH;
						end
					end else if (sweep_end) begin
						emit_mask_q <= mask_left;
						idx_q       <= '0;
						if (mask_left == '0) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (space) begin
						out_q       <= '{last: 1'b1, found: pend_vld_q,
							symbol: pend_vld_q ? pend_sym_q : '0};
						out_vld_q   <= 1'b1;
						cnt_q       <= '0;
						idx_q       <= '0;
						nullable_q  <= '0;
						emit_mask_q <= '0;
						found_q     <= '0;
						pend_vld_q  <= 1'b0;
						state_q     <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign res     = out_q;
	assign res_vld = out_vld_q;

`ifndef SYNTHESIS
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (nullable_q == '0) && !pend_vld_q && (emit_mask_q == '0))
		else $error("run state left over while loading");
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && ((state_q == ST_PASS) || (state_q == ST_EMIT)))
			|-> (CNT_W'(rd_idx_s1) < cnt_q))
		else $error("read beyond loaded rules");
	a_emit_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (emit_mask_q != '0))
		else $error("emitting with no letter left");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> rd_vld_s1 && $stable(rd_idx_s1))
		else $error("stalled read data lost");
`endif

endmodule

`default_nettype wire
